// File: design/ufdx_pkg.sv
package ufdx_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 128;

    localparam logic [7:0] START_BYTE = 8'hFF;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_CTS      = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    // queue between parser and output stage, power of two
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] position;
        logic       last_byte;
        logic       check_ok;
    } result_t;

endpackage

// File: design/ufdx_front.sv
module ufdx_front #(
    parameter int unsigned MAX_PAYLOAD = ufdx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    output logic              push_valid,
    input  logic              push_ready,
    output ufdx_pkg::result_t push_data
);
    import ufdx_pkg::*;

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] xor_reg, xor_next;
    logic       accept;
    logic       has_result;
    logic [8:0] cnt_inc;
    result_t    rec;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign cnt_inc  = {1'b0, cnt_reg} + 9'd1;

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        has_result = 1'b0;
        rec        = '0;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_tdata == START_BYTE) begin
                        xor_next   = START_BYTE;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (s_tdata == 8'd0) begin
                        has_result = 1'b1;
                        rec.kind   = KIND_CTS;
                        phase_next = PH_HUNT;
                    end else if (s_tdata > MAX_LEN) begin
                        has_result = 1'b1;
                        rec.kind   = KIND_TOO_LONG;
                        rec.data   = s_tdata;
                        phase_next = PH_HUNT;
                    end else begin
                        len_next   = s_tdata;
                        cnt_next   = 8'd0;
                        xor_next   = xor_reg ^ s_tdata;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    has_result    = 1'b1;
                    rec.kind      = KIND_PAYLOAD;
                    rec.data      = s_tdata;
                    rec.position  = cnt_reg;
                    rec.last_byte = (cnt_inc >= {1'b0, len_reg});
                    xor_next      = xor_reg ^ s_tdata;
                    cnt_next      = cnt_inc[7:0];
                    if (rec.last_byte) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    has_result   = 1'b1;
                    rec.kind     = KIND_END;
                    rec.data     = len_reg;
                    rec.check_ok = (s_tdata == xor_reg);
                    phase_next   = PH_HUNT;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    assign push_valid = has_result;
    assign push_data  = rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            xor_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

// File: design/ufdx_queue.sv
module ufdx_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  ufdx_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ufdx_pkg::result_t pop_data
);
    import ufdx_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    result_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/ufdx_back.sv
module ufdx_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  ufdx_pkg::result_t pop_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import ufdx_pkg::*;

    result_t out_reg;
    logic    valid_reg, valid_next;
    logic    load;

    assign pop_ready  = !valid_reg || m_tready;
    assign load       = pop_valid && pop_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, out_reg.check_ok, out_reg.position, out_reg.data};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_byte;

endmodule

// File: design/uart_frame_deframer_xor_check.sv
// channel  | dir | ports                           | word
// ---------+-----+---------------------------------+---------------------------------------
// s_ (rx)  | in  | s_tvalid s_tready s_tdata[7:0]  | rx_byte
// m_ (res) | out | m_tvalid m_tready m_tdata[23:0] | data, position, check_ok; kind in
//          |     | m_tuser[1:0] m_tlast            | m_tuser, last_byte on m_tlast
//
// one input word per cycle while s_tready is high; the parser state machine updates
// phase, count and xor in the cycle a word is accepted, and each result is written
// into the queue and then loaded into the output register before it reaches m_tdata
// synchronous active-low reset returns the parser to hunting for the start byte
// and empties the queue and the output register
// s_tready drops only when the four-entry result queue is full; the output
// register keeps draining the queue while m_tready is high
module uart_frame_deframer_xor_check #(
    parameter int unsigned MAX_PAYLOAD = ufdx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data, [15:8] position, [16] check_ok, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_byte
);
    import ufdx_pkg::*;

    // parser to queue
    logic    push_valid;
    logic    push_ready;
    result_t push_data;

    // queue to output stage
    logic    pop_valid;
    logic    pop_ready;
    result_t pop_data;

    // front: start hunt, length check, payload indexing and running xor
    ufdx_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data)
    );

    // short queue so the parser and the output side stall independently
    ufdx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    // back: registered result word on the master side
    ufdx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
